// File: hdl/lmpb_pkg.sv
// Shared command codes and command beat type for the LED plane buffer.
`default_nettype none
package lmpb_pkg;

  // Command codes
  localparam logic [3:0] FN_CLEAR      = 4'd0;
  localparam logic [3:0] FN_WR_COLUMN  = 4'd1;
  localparam logic [3:0] FN_WR_ROW     = 4'd2;
  localparam logic [3:0] FN_SCROLL_L   = 4'd3;
  localparam logic [3:0] FN_SCROLL_D   = 4'd4;
  localparam logic [3:0] FN_SLIDE_L    = 4'd5;
  localparam logic [3:0] FN_SLIDE_R    = 4'd6;
  localparam logic [3:0] FN_SET_CELL   = 4'd7;
  localparam logic [3:0] FN_READ_CELL  = 4'd8;

  // Plane select codes
  localparam logic [1:0] COLOR_BLUE    = 2'd0;
  localparam logic [1:0] COLOR_YELLOW  = 2'd1;
  localparam logic [1:0] COLOR_BOTH    = 2'd2;

  localparam int PATTERN_W = 8;

  // One command beat as seen by a plane update unit
  typedef struct packed {
    logic [3:0]           func;
    logic [2:0]           column;
    logic [2:0]           row;
    logic [PATTERN_W-1:0] pattern;
    logic                 cell_value;
  } cmd_t;

endpackage
`default_nettype wire

// File: hdl/lmpb_plane_alu.sv
// Next-state logic for one LED plane: every cell updated in parallel.
`default_nettype none
module lmpb_plane_alu #(
  parameter int NUM_COLUMNS = 8,
  parameter int NUM_ROWS    = 8
) (
  input  lmpb_pkg::cmd_t                        cmd,
  input  logic                                  enable,
  input  logic                                  clear_all,
  input  logic [NUM_COLUMNS-1:0][NUM_ROWS-1:0]  plane,
  output logic [NUM_COLUMNS-1:0][NUM_ROWS-1:0]  plane_nxt
);
  import lmpb_pkg::*;

  logic [NUM_COLUMNS-1:0] pbits;    // pattern bit per column, column 0 takes the high bit
  logic [NUM_ROWS-1:0]    colword;  // pattern cut to a column word

  // Pattern bit lanes
  always_comb begin
    for (int c = 0; c < NUM_COLUMNS; c++) begin
      int pos;
      pos = NUM_COLUMNS - 1 - c;
      pbits[c] = (pos < PATTERN_W) ? cmd.pattern[pos[2:0]] : 1'b0;
    end
    for (int r = 0; r < NUM_ROWS; r++) begin
      colword[r] = (r < PATTERN_W) ? cmd.pattern[r[2:0]] : 1'b0;
    end
  end

  // Per-cell update
  always_comb begin
    for (int c = 0; c < NUM_COLUMNS; c++) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        logic col_hit;
        logic row_hit;
        col_hit = (32'(cmd.column) == c);
        row_hit = (32'(cmd.row) == r);
        plane_nxt[c][r] = plane[c][r];
        if (clear_all) begin
          plane_nxt[c][r] = 1'b0;
        end else if (enable) begin
          case (cmd.func)
            FN_CLEAR:     plane_nxt[c][r] = 1'b0;
            FN_WR_COLUMN: if (col_hit) plane_nxt[c][r] = colword[r];
            FN_WR_ROW:    if (row_hit) plane_nxt[c][r] = pbits[c];
            FN_SCROLL_L: begin
              if (c == NUM_COLUMNS - 1) plane_nxt[c][r] = colword[r];
              else                      plane_nxt[c][r] = plane[c+1][r];
            end
            FN_SCROLL_D: begin
              if (r == 0) plane_nxt[c][r] = pbits[c];
              else        plane_nxt[c][r] = plane[c][r-1];
            end
            FN_SLIDE_L: begin
              if (row_hit) begin
                if (c == NUM_COLUMNS - 1) plane_nxt[c][r] = 1'b0;
                else                      plane_nxt[c][r] = plane[c+1][r];
              end
            end
            FN_SLIDE_R: begin
              if (row_hit) begin
                if (c == 0) plane_nxt[c][r] = 1'b0;
                else        plane_nxt[c][r] = plane[c-1][r];
              end
            end
            FN_SET_CELL:  if (col_hit && row_hit) plane_nxt[c][r] = cmd.cell_value;
            default:      plane_nxt[c][r] = plane[c][r];
          endcase
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/led_matrix_plane_buffer_engine_core.sv
// Top level: two LED planes, their update units and the result register.
// A result appears in the output register in the cycle after its command beat is accepted.
// Throughput: one command per cycle unless stalled; both planes update every cell in parallel.
// A held result stalls the input only while out_ready is low.
// Reset (rst_n low, synchronous) clears both planes and the output valid flag.
`default_nettype none
module led_matrix_plane_buffer_engine_core #(
  parameter int NUM_COLUMNS = 8,
  parameter int NUM_ROWS    = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [3:0] in_func,
  input  logic [1:0] in_color,
  input  logic [2:0] in_column,
  input  logic [2:0] in_row,
  input  logic [7:0] in_pattern,
  input  logic       in_cell_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_cell_bit,
  output logic [7:0] out_column_out
);
  import lmpb_pkg::*;

  typedef logic [NUM_COLUMNS-1:0][NUM_ROWS-1:0] plane_t;

  plane_t     blue_r, yellow_r;
  plane_t     blue_nxt, yellow_nxt;
  cmd_t       cmd;
  logic       accept;
  logic       blue_en, yellow_en, clear_both;
  logic       out_valid_r;
  logic       cell_bit_r, cell_bit_nxt;
  logic [7:0] column_out_r, column_out_nxt;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign cmd = '{func: in_func, column: in_column, row: in_row,
                 pattern: in_pattern, cell_value: in_cell_value};

  // Plane select
  assign blue_en    = (in_color == COLOR_BLUE);
  assign yellow_en  = (in_color == COLOR_YELLOW);
  assign clear_both = (in_color == COLOR_BOTH) && (in_func == FN_CLEAR);

  lmpb_plane_alu #(.NUM_COLUMNS(NUM_COLUMNS), .NUM_ROWS(NUM_ROWS)) u_blue (
    .cmd(cmd), .enable(blue_en), .clear_all(clear_both),
    .plane(blue_r), .plane_nxt(blue_nxt)
  );

  lmpb_plane_alu #(.NUM_COLUMNS(NUM_COLUMNS), .NUM_ROWS(NUM_ROWS)) u_yellow (
    .cmd(cmd), .enable(yellow_en), .clear_all(clear_both),
    .plane(yellow_r), .plane_nxt(yellow_nxt)
  );

  // Readback of the addressed column and cell after the update; zero unless one plane is selected
  always_comb begin
    logic [NUM_ROWS-1:0] sel_col;
    logic                col_ok, row_ok;
    sel_col = '0;
    col_ok  = (32'(in_column) < NUM_COLUMNS);
    row_ok  = (32'(in_row) < NUM_ROWS);
    for (int c = 0; c < NUM_COLUMNS; c++) begin
      if (32'(in_column) == c) sel_col = yellow_en ? yellow_nxt[c] : blue_nxt[c];
    end
    column_out_nxt = '0;
    cell_bit_nxt   = 1'b0;
    if ((blue_en || yellow_en) && col_ok) begin
      for (int b = 0; b < 8; b++) begin
        column_out_nxt[b] = (b < NUM_ROWS) ? sel_col[b] : 1'b0;
      end
      if (row_ok) begin
        for (int r = 0; r < NUM_ROWS; r++) begin
          if (32'(in_row) == r) cell_bit_nxt = sel_col[r];
        end
      end
    end
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blue_r      <= '0;
      yellow_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        blue_r   <= blue_nxt;
        yellow_r <= yellow_nxt;
      end
      if (accept)         out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cell_bit_r   <= cell_bit_nxt;
      column_out_r <= column_out_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_bit   = cell_bit_r;
  assign out_column_out = column_out_r;

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the two-plane LED matrix buffer engine.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lmpb_pkg::*;

  // Codes the package leaves unnamed
  localparam logic [3:0] FN_UNUSED_FIRST = 4'd9;
  localparam logic [3:0] FN_UNUSED_LAST  = 4'd15;
  localparam logic [1:0] COLOR_NONE      = 2'd3;

  localparam int N_COLS        = 8;
  localparam int RANDOM_CMDS   = 850;
  localparam int IDLE_LIMIT    = 2000;
  localparam int MAX_REPORTS   = 10;

  // Expected readback of one command, with the command kept for messages
  typedef struct {
    logic       cell_bit;
    logic [7:0] column_out;
    logic [3:0] func;
    logic [1:0] color;
    logic [2:0] column;
    logic [2:0] row;
  } readback_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [3:0] in_func = '0;
  logic [1:0] in_color = '0;
  logic [2:0] in_column = '0;
  logic [2:0] in_row = '0;
  logic [7:0] in_pattern = '0;
  logic       in_cell_value = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_cell_bit;
  logic [7:0] out_column_out;

  // Shadow planes: index 0 blue, 1 yellow; both start empty like the planes after reset
  logic [7:0] shadow_plane [2][N_COLS] = '{default: '0};
  readback_t  readback_q [$];

  int burst_left = 0;
  int cmds_sent = 0;
  int directed_cmds = 0;
  int readbacks_checked = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  logic [15:0] stall_pat;
  int stall_age;

  led_matrix_plane_buffer_engine_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_color       (in_color),
    .in_column      (in_column),
    .in_row         (in_row),
    .in_pattern     (in_pattern),
    .in_cell_value  (in_cell_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_bit   (out_cell_bit),
    .out_column_out (out_column_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void log_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("MISMATCH: %s", msg);
  endfunction

  // Update the shadow planes for one command and return its readback
  function automatic void predict_command(input logic [3:0] fn, input logic [1:0] color,
                                          input logic [2:0] col, input logic [2:0] row,
                                          input logic [7:0] pat, input logic val,
                                          output logic bit_o, output logic [7:0] col_o);
    int p;
    bit_o = 1'b0;
    col_o = '0;
    if (color == COLOR_BOTH) begin
      if (fn == FN_CLEAR) begin
        for (int i = 0; i < N_COLS; i++) begin
          shadow_plane[0][i] = '0;
          shadow_plane[1][i] = '0;
        end
      end
      return;
    end
    if (color == COLOR_NONE) return;
    p = (color == COLOR_YELLOW) ? 1 : 0;
    case (fn)
      FN_CLEAR: begin
        for (int i = 0; i < N_COLS; i++) shadow_plane[p][i] = '0;
      end
      FN_WR_COLUMN: shadow_plane[p][col] = pat;
      // column 0 takes the top pattern bit
      FN_WR_ROW: begin
        for (int i = 0; i < N_COLS; i++) shadow_plane[p][i][row] = pat[N_COLS-1-i];
      end
      FN_SCROLL_L: begin
        for (int i = 1; i < N_COLS; i++) shadow_plane[p][i-1] = shadow_plane[p][i];
        shadow_plane[p][N_COLS-1] = pat;
      end
      FN_SCROLL_D: begin
        for (int i = 0; i < N_COLS; i++)
          shadow_plane[p][i] = {shadow_plane[p][i][6:0], pat[N_COLS-1-i]};
      end
      FN_SLIDE_L: begin
        for (int i = 1; i < N_COLS; i++) shadow_plane[p][i-1][row] = shadow_plane[p][i][row];
        shadow_plane[p][N_COLS-1][row] = 1'b0;
      end
      FN_SLIDE_R: begin
        for (int i = N_COLS - 1; i > 0; i--)
          shadow_plane[p][i][row] = shadow_plane[p][i-1][row];
        shadow_plane[p][0][row] = 1'b0;
      end
      FN_SET_CELL: shadow_plane[p][col][row] = val;
      default: ;
    endcase
    col_o = shadow_plane[p][col];
    bit_o = shadow_plane[p][col][row];
  endfunction

  // Send one command beat; the sender may idle between random bursts
  task automatic send_cmd(input logic [3:0] fn, input logic [1:0] color,
                          input logic [2:0] col, input logic [2:0] row,
                          input logic [7:0] pat, input logic val);
    int gap;
    readback_t rb;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_func       <= fn;
    in_color      <= color;
    in_column     <= col;
    in_row        <= row;
    in_pattern    <= pat;
    in_cell_value <= val;
    do @(posedge clk); while (!in_ready);
    cmds_sent++;
    predict_command(fn, color, col, row, pat, val, rb.cell_bit, rb.column_out);
    rb.func = fn;
    rb.color = color;
    rb.column = col;
    rb.row = row;
    readback_q.push_back(rb);
  endtask

  // Column and row writes at the field extremes
  task automatic test_column_and_row_writes();
    send_cmd(FN_WR_COLUMN, COLOR_BLUE,   3'd0, 3'd0, 8'hFF, 1'b0);
    send_cmd(FN_WR_COLUMN, COLOR_YELLOW, 3'd7, 3'd7, 8'hA5, 1'b1);
    send_cmd(FN_WR_ROW,    COLOR_BLUE,   3'd0, 3'd7, 8'h80, 1'b0);
    send_cmd(FN_WR_ROW,    COLOR_YELLOW, 3'd7, 3'd0, 8'hFF, 1'b0);
    // zero pattern bits must clear on the blue plane too
    send_cmd(FN_WR_ROW,    COLOR_BLUE,   3'd0, 3'd0, 8'h00, 1'b0);
  endtask

  task automatic test_scrolls();
    send_cmd(FN_SCROLL_L, COLOR_BLUE,   3'd7, 3'd3, 8'h81, 1'b0);
    send_cmd(FN_SCROLL_D, COLOR_YELLOW, 3'd0, 3'd0, 8'h80, 1'b0);
    send_cmd(FN_SCROLL_D, COLOR_BLUE,   3'd6, 3'd7, 8'hFF, 1'b1);
  endtask

  task automatic test_slides();
    send_cmd(FN_SLIDE_L, COLOR_BLUE,   3'd6, 3'd7, 8'h00, 1'b0);
    send_cmd(FN_SLIDE_R, COLOR_YELLOW, 3'd1, 3'd0, 8'h00, 1'b0);
    send_cmd(FN_SLIDE_R, COLOR_BLUE,   3'd0, 3'd7, 8'hFF, 1'b1);
  endtask

  task automatic test_cell_access();
    send_cmd(FN_SET_CELL,  COLOR_BLUE,   3'd3, 3'd5, 8'h00, 1'b1);
    send_cmd(FN_SET_CELL,  COLOR_YELLOW, 3'd7, 3'd7, 8'hFF, 1'b1);
    send_cmd(FN_SET_CELL,  COLOR_BLUE,   3'd0, 3'd7, 8'h00, 1'b0);
    send_cmd(FN_READ_CELL, COLOR_BLUE,   3'd3, 3'd5, 8'h00, 1'b0);
    send_cmd(FN_READ_CELL, COLOR_YELLOW, 3'd7, 3'd7, 8'h00, 1'b0);
  endtask

  // Both-planes select, the unused select code, and the clears
  task automatic test_color_codes();
    send_cmd(FN_WR_COLUMN, COLOR_BOTH,   3'd7, 3'd7, 8'h3C, 1'b1);
    send_cmd(FN_READ_CELL, COLOR_NONE,   3'd7, 3'd7, 8'h00, 1'b0);
    send_cmd(FN_CLEAR,     COLOR_BLUE,   3'd0, 3'd0, 8'h00, 1'b0);
    send_cmd(FN_CLEAR,     COLOR_BOTH,   3'd7, 3'd7, 8'hFF, 1'b1);
    send_cmd(FN_READ_CELL, COLOR_YELLOW, 3'd7, 3'd7, 8'h00, 1'b0);
  endtask

  // Unused command codes behave as a plain readback
  task automatic test_unused_codes();
    send_cmd(FN_WR_COLUMN,    COLOR_YELLOW, 3'd2, 3'd4, 8'h5A, 1'b0);
    send_cmd(FN_UNUSED_FIRST, COLOR_YELLOW, 3'd2, 3'd4, 8'hFF, 1'b1);
    send_cmd(FN_UNUSED_LAST,  COLOR_BLUE,   3'd2, 3'd4, 8'hFF, 1'b1);
  endtask

  // Mostly plane-building commands on one plane, so the planes fill up
  task automatic test_random_traffic(input int n);
    int w;
    int c;
    logic [3:0] fn;
    logic [1:0] color;
    for (int k = 0; k < n; k++) begin
      w = $urandom_range(0, 99);
      if (w < 3)       fn = FN_CLEAR;
      else if (w < 15) fn = FN_WR_COLUMN;
      else if (w < 27) fn = FN_WR_ROW;
      else if (w < 37) fn = FN_SCROLL_L;
      else if (w < 47) fn = FN_SCROLL_D;
      else if (w < 57) fn = FN_SLIDE_L;
      else if (w < 67) fn = FN_SLIDE_R;
      else if (w < 80) fn = FN_SET_CELL;
      else if (w < 93) fn = FN_READ_CELL;
      else             fn = 4'($urandom_range(FN_UNUSED_FIRST, FN_UNUSED_LAST));
      c = $urandom_range(0, 19);
      if (c < 9)        color = COLOR_BLUE;
      else if (c < 18)  color = COLOR_YELLOW;
      else if (c == 18) color = COLOR_BOTH;
      else              color = COLOR_NONE;
      send_cmd(fn, color, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
               8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  // Receiver: rotate a stall pattern, re-chosen each time stall_age wraps
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_pat <= 16'hFFFF;
      stall_age <= 0;
    end else begin
      out_ready <= stall_pat[0];
      if (stall_age == 63) begin
        stall_age <= 0;
        case ($urandom_range(0, 2))
          0:       stall_pat <= 16'hFFFF;
          1:       stall_pat <= 16'($urandom_range(0, 65535)) | 16'h0001;
          default: stall_pat <= 16'($urandom_range(0, 65535) & $urandom_range(0, 65535))
                                | 16'h0001;
        endcase
      end else begin
        stall_age <= stall_age + 1;
        stall_pat <= {stall_pat[0], stall_pat[15:1]};
      end
    end
  end

  // Readback checker
  always @(posedge clk) begin
    readback_t want;
    if (rst_n && out_valid && out_ready) begin
      readbacks_checked++;
      if (readback_q.size() == 0) begin
        log_mismatch($sformatf("readback with no command outstanding: cell_bit=%0b column=%02h",
                               out_cell_bit, out_column_out));
      end else begin
        want = readback_q.pop_front();
        if (out_cell_bit !== want.cell_bit || out_column_out !== want.column_out)
          log_mismatch($sformatf(
            "func=%0d color=%0d col=%0d row=%0d: cell_bit exp %0b got %0b, column exp %02h got %02h",
            want.func, want.color, want.column, want.row, want.cell_bit, out_cell_bit,
            want.column_out, out_column_out));
      end
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no beat for %0d cycles, %0d readbacks outstanding",
                 IDLE_LIMIT, readback_q.size());
        $display("[led_matrix_plane_buffer_engine_core] ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_column_and_row_writes();
    test_scrolls();
    test_slides();
    test_cell_access();
    test_color_codes();
    test_unused_codes();
    directed_cmds = cmds_sent;
    test_random_traffic(RANDOM_CMDS);
    in_valid <= 1'b0;
    while (readback_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (readback_q.size() != 0)
      log_mismatch($sformatf("%0d readbacks never arrived", readback_q.size()));
    $display("Sent %0d commands (%0d directed, rest random over both planes and all codes).",
             cmds_sent, directed_cmds);
    $display("Checked %0d readbacks under bursty input and patterned output stalls; %0d mismatches.",
             readbacks_checked, mismatches);
    if (mismatches == 0) begin
      $display("[led_matrix_plane_buffer_engine_core] OK");
    end else begin
      $display("[led_matrix_plane_buffer_engine_core] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/lmpb_pkg.sv
hdl/lmpb_plane_alu.sv
hdl/led_matrix_plane_buffer_engine_core.sv
tb/tb_top.sv
